// ----- design/sparse_set_slot_manager_defines.svh -----
// ----------------------------------------------------------------------------
// Sparse set slot manager: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_SET_SLOT_MANAGER_DEFINES_SVH
`define SPARSE_SET_SLOT_MANAGER_DEFINES_SVH

// Same-cycle implication.
`define SSM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sparse set slot manager: property violated");

// Next-cycle implication.
`define SSM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sparse set slot manager: property violated");

`endif

// ----- design/ssm_pkg.sv -----
// ----------------------------------------------------------------------------
// ssm_pkg
// Sizes, codes and the control/status bundles of the sparse set slot manager.
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam int ENTITY_SPACE  = 4096;
  localparam int SLOT_CAPACITY = 4096;

  localparam int MAP_AW  = $clog2(ENTITY_SPACE);
  localparam int SLOT_W  = $clog2(SLOT_CAPACITY);
  localparam int COUNT_W = $clog2(SLOT_CAPACITY + 1);

  // transaction field widths
  localparam int KIND_W        = 2;
  localparam int ENT_W         = 12;
  localparam int STATUS_W      = 2;
  localparam int SLOT_FIELD_W  = 12;
  localparam int COUNT_FIELD_W = 13;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD,
    KIND_LOOKUP,
    KIND_REMOVE
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE,
    ST_ABSENT,
    ST_FULL
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_FIX,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } map_entry_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic eval;
    logic fix;
    logic load_out;
    logic out_from_eval;
  } ssm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_fix;
  } ssm_stat_t;

  typedef struct packed {
    status_t                    status;
    logic [SLOT_FIELD_W-1:0]    slot;
    logic                       moved;
    logic [SLOT_FIELD_W-1:0]    moved_from_slot;
    logic [COUNT_FIELD_W-1:0]   live_count;
  } result_t;

endpackage

// ----- design/ssm_in_if.sv -----
// ----------------------------------------------------------------------------
// ssm_in_if
// Request channel: operation kind and entity index with valid/ready.
// ----------------------------------------------------------------------------
interface ssm_in_if;
  logic                         valid;
  logic                         ready;
  logic [ssm_pkg::KIND_W-1:0]   kind;
  logic [ssm_pkg::ENT_W-1:0]    entity_index;

  modport source (output valid, kind, entity_index, input ready);
  modport sink   (input valid, kind, entity_index, output ready);
endinterface

// ----- design/ssm_out_if.sv -----
// ----------------------------------------------------------------------------
// ssm_out_if
// Response channel: status, slot, move report and live count with valid/ready.
// ----------------------------------------------------------------------------
interface ssm_out_if;
  logic                               valid;
  logic                               ready;
  logic [ssm_pkg::STATUS_W-1:0]       status;
  logic [ssm_pkg::SLOT_FIELD_W-1:0]   slot;
  logic                               moved;
  logic [ssm_pkg::SLOT_FIELD_W-1:0]   moved_from_slot;
  logic [ssm_pkg::COUNT_FIELD_W-1:0]  live_count;

  modport source (output valid, status, slot, moved, moved_from_slot, live_count,
                  input ready);
  modport sink   (input valid, status, slot, moved, moved_from_slot, live_count,
                  output ready);
endinterface

// ----- design/ssm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssm_ctrl
// Sequencer: clearing pass, accept, evaluate, move fix-up and response hand-off.
// ----------------------------------------------------------------------------
module ssm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ssm_pkg::ssm_stat_t stat,
  output ssm_pkg::ssm_cmd_t  cmd
);

  ssm_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            emit_ok;

  assign emit_ok   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssm_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ssm_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ssm_pkg::S_IDLE;
      end
      ssm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ssm_pkg::S_EVAL;
        end
      end
      ssm_pkg::S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.need_fix) begin
          state_nxt = ssm_pkg::S_FIX;
        end else if (emit_ok) begin
          cmd.load_out      = 1'b1;
          cmd.out_from_eval = 1'b1;
          out_valid_nxt     = 1'b1;
          state_nxt         = ssm_pkg::S_IDLE;
        end else begin
          state_nxt = ssm_pkg::S_EMIT;
        end
      end
      ssm_pkg::S_FIX: begin
        cmd.fix = 1'b1;
        if (emit_ok) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ssm_pkg::S_IDLE;
        end else begin
          state_nxt = ssm_pkg::S_EMIT;
        end
      end
      ssm_pkg::S_EMIT: begin
        if (emit_ok) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ssm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ssm_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

// ----- design/ssm_datapath.sv -----
// ----------------------------------------------------------------------------
// ssm_datapath
// Sparse map and dense list memories, entry count, and response registers.
// ----------------------------------------------------------------------------
module ssm_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ssm_pkg::ssm_cmd_t                  cmd,
  output ssm_pkg::ssm_stat_t                 stat,
  input  logic [ssm_pkg::KIND_W-1:0]         in_kind,
  input  logic [ssm_pkg::ENT_W-1:0]          in_entity_index,
  output ssm_pkg::result_t                   out_res
);

  // storage; the map is cleared by the sweep after reset, the list never is
  ssm_pkg::map_entry_t              map_mem   [ssm_pkg::ENTITY_SPACE];
  logic [ssm_pkg::ENT_W-1:0]        dense_mem [ssm_pkg::SLOT_CAPACITY];

  logic [ssm_pkg::MAP_AW-1:0]       clr_cnt_r;
  logic [ssm_pkg::COUNT_W-1:0]      count_r, count_nxt;
  logic [ssm_pkg::KIND_W-1:0]       kind_r;
  logic [ssm_pkg::ENT_W-1:0]        ent_r;
  ssm_pkg::map_entry_t              map_rd_r;
  logic [ssm_pkg::ENT_W-1:0]        dense_rd_r;
  ssm_pkg::result_t                 res_r, res_comb, out_r;

  logic                             in_range, found, full;
  logic                             add_wr, rem, moved;
  logic [ssm_pkg::SLOT_W-1:0]       last, slot_v;
  ssm_pkg::status_t                 status_v;

  logic                             map_we;
  logic [ssm_pkg::MAP_AW-1:0]       map_wa;
  ssm_pkg::map_entry_t              map_wd;
  logic                             dense_we;
  logic [ssm_pkg::SLOT_W-1:0]       dense_wa;
  logic [ssm_pkg::ENT_W-1:0]        dense_wd;

  assign last     = ssm_pkg::SLOT_W'(count_r - ssm_pkg::COUNT_W'(1));
  assign in_range = 32'(ent_r) < ssm_pkg::ENTITY_SPACE;
  assign full     = count_r >= ssm_pkg::COUNT_W'(ssm_pkg::SLOT_CAPACITY);
  assign found    = in_range && map_rd_r.valid &&
                    (ssm_pkg::COUNT_W'(map_rd_r.slot) < count_r);

  // decision for the request held in kind_r / ent_r
  always_comb begin
    status_v = ssm_pkg::ST_ABSENT;
    slot_v   = '0;
    add_wr   = 1'b0;
    rem      = 1'b0;
    moved    = 1'b0;
    case (kind_r)
      ssm_pkg::KIND_ADD: begin
        if (found) begin
          slot_v = map_rd_r.slot;
        end else if (!in_range || full) begin
          status_v = ssm_pkg::ST_FULL;
        end else begin
          add_wr   = 1'b1;
          status_v = ssm_pkg::ST_DONE;
          slot_v   = ssm_pkg::SLOT_W'(count_r);
        end
      end
      ssm_pkg::KIND_LOOKUP: begin
        if (found) begin
          status_v = ssm_pkg::ST_DONE;
          slot_v   = map_rd_r.slot;
        end
      end
      ssm_pkg::KIND_REMOVE: begin
        if (found) begin
          rem      = 1'b1;
          moved    = map_rd_r.slot != last;
          status_v = ssm_pkg::ST_DONE;
          slot_v   = map_rd_r.slot;
        end
      end
      default: begin
        status_v = ssm_pkg::ST_ABSENT;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (add_wr)   count_nxt = count_r + ssm_pkg::COUNT_W'(1);
    else if (rem) count_nxt = count_r - ssm_pkg::COUNT_W'(1);
  end

  always_comb begin
    res_comb.status          = status_v;
    res_comb.slot            = ssm_pkg::SLOT_FIELD_W'(slot_v);
    res_comb.moved           = moved;
    res_comb.moved_from_slot = moved ? ssm_pkg::SLOT_FIELD_W'(last) : '0;
    res_comb.live_count      = ssm_pkg::COUNT_FIELD_W'(count_nxt);
  end

  assign stat.clr_last = clr_cnt_r == ssm_pkg::MAP_AW'(ssm_pkg::ENTITY_SPACE - 1);
  assign stat.need_fix = rem && moved;

  // map write port: sweep, own entry on evaluate, moved entity on fix-up
  always_comb begin
    map_we = 1'b0;
    map_wa = ssm_pkg::MAP_AW'(ent_r);
    map_wd = '0;
    if (cmd.clr_step) begin
      map_we = 1'b1;
      map_wa = clr_cnt_r;
    end else if (cmd.eval && add_wr) begin
      map_we       = 1'b1;
      map_wd.valid = 1'b1;
      map_wd.slot  = ssm_pkg::SLOT_W'(count_r);
    end else if (cmd.eval && rem) begin
      map_we = 1'b1;
    end else if (cmd.fix) begin
      map_we       = 1'b1;
      map_wa       = ssm_pkg::MAP_AW'(dense_rd_r);
      map_wd.valid = 1'b1;
      map_wd.slot  = map_rd_r.slot;
    end
  end

  always_comb begin
    dense_we = 1'b0;
    dense_wa = ssm_pkg::SLOT_W'(count_r);
    dense_wd = ent_r;
    if (cmd.eval && add_wr) begin
      dense_we = 1'b1;
    end else if (cmd.eval && rem && moved) begin
      dense_we = 1'b1;
      dense_wa = map_rd_r.slot;
      dense_wd = dense_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (cmd.accept) map_rd_r <= map_mem[ssm_pkg::MAP_AW'(in_entity_index)];
  end

  always_ff @(posedge clk) begin
    if (dense_we) dense_mem[dense_wa] <= dense_wd;
    if (cmd.accept) dense_rd_r <= dense_mem[last];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      count_r   <= '0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + ssm_pkg::MAP_AW'(1);
      if (cmd.eval)     count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= in_kind;
      ent_r  <= in_entity_index;
    end
    if (cmd.eval) res_r <= res_comb;
    if (cmd.load_out) out_r <= cmd.out_from_eval ? res_comb : res_r;
  end

  assign out_res = out_r;

endmodule

// ----- design/sparse_set_slot_manager.sv -----
// ----------------------------------------------------------------------------
// sparse_set_slot_manager
// Response: registered when the evaluate state ends, or the fix-up state for a
// remove that moves an entry; a response still held at the output adds stalls.
// Sequence: add and lookup pass through accept and evaluate; a remove that
// moves an entry adds a fix-up state, set by the single write port of the
// sparse map (two map writes). Reset: rst_n clears count and control, then a
// sweep over all 4096 entries empties the sparse map with in_chan.ready low.
// ----------------------------------------------------------------------------
module sparse_set_slot_manager (
  input  logic        clk,
  input  logic        rst_n,
  ssm_in_if.sink      in_chan,
  ssm_out_if.source   out_chan
);

  // Controller and datapath exchange only the command and status bundles.
  // The request is captured and both memories are read on the accepting edge;
  // the next cycle decides the outcome and performs the writes. A remove that
  // relocates the last dense entry needs a further fix-up state to repoint that
  // entity's map entry. The response register lets a new request in while the
  // previous response is still waiting to be taken.

  ssm_pkg::ssm_cmd_t  cmd;
  ssm_pkg::ssm_stat_t stat;
  ssm_pkg::result_t   res;

  ssm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ssm_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_chan.kind),
    .in_entity_index (in_chan.entity_index),
    .out_res         (res)
  );

  // response payload straight from the output register
  assign out_chan.status          = res.status;
  assign out_chan.slot            = res.slot;
  assign out_chan.moved           = res.moved;
  assign out_chan.moved_from_slot = res.moved_from_slot;
  assign out_chan.live_count      = res.live_count;

endmodule

// ----- design/ssm_props.sv -----
// ----------------------------------------------------------------------------
// ssm_props
// Port-level checks of the sparse set slot manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "sparse_set_slot_manager_defines.svh"

module ssm_props (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [ssm_pkg::STATUS_W-1:0]       out_status,
  input logic [ssm_pkg::SLOT_FIELD_W-1:0]   out_slot,
  input logic                               out_moved,
  input logic [ssm_pkg::SLOT_FIELD_W-1:0]   out_moved_from_slot,
  input logic [ssm_pkg::COUNT_FIELD_W-1:0]  out_live_count
);

  // one request in flight: the cycle after a transaction is never ready
  `SSM_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // a stalled response holds
  `SSM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_slot) && $stable(out_status) && $stable(out_live_count) && $stable(out_moved_from_slot))

  // a move only follows a successful remove, from a different slot
  `SSM_ASSERT_IMP(a_move_ok, out_valid && out_moved, out_status == ssm_pkg::ST_DONE && out_moved_from_slot != out_slot)

  // a full set reports no slot and no move
  `SSM_ASSERT_IMP(a_full_clean, out_valid && out_status == ssm_pkg::ST_FULL, out_slot == '0 && !out_moved && out_moved_from_slot == '0)

endmodule

bind sparse_set_slot_manager ssm_props u_ssm_props (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_chan.valid),
  .in_ready            (in_chan.ready),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_status          (out_chan.status),
  .out_slot            (out_chan.slot),
  .out_moved           (out_chan.moved),
  .out_moved_from_slot (out_chan.moved_from_slot),
  .out_live_count      (out_chan.live_count)
);

// ----- tb/ssm_checker.sv -----
// ----------------------------------------------------------------------------
// ssm_checker
// Watches the request and response channels of the sparse set slot manager,
// keeps its own copy of the entity map, slot owners and live count, predicts
// each response and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ssm_checker
  import ssm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ssm_in_if    in_mon,
  ssm_out_if   out_mon,
  output int   mismatches,
  output int   outstanding
);

  localparam int REPORT_LIMIT = 10;

  map_entry_t           entity_map  [ENTITY_SPACE];
  logic [ENT_W-1:0]     slot_owner  [SLOT_CAPACITY];
  logic [COUNT_W-1:0]   live_entries;
  result_t              pending_responses[$];
  int                   error_total = 0;

  // Applies one request to the shadow state and returns the response it earns.
  // Indices are 12 bits wide and the entity space is 4096, so every index can
  // be stored.
  function automatic result_t resolve_request(logic [KIND_W-1:0] kind,
                                              logic [ENT_W-1:0]  ent);
    result_t            r;
    logic               hit;
    logic [SLOT_W-1:0]  s;
    logic [SLOT_W-1:0]  last;
    logic [COUNT_W-1:0] shrunk;
    logic [ENT_W-1:0]   other;
    r        = '0;
    r.status = ST_ABSENT;
    s        = entity_map[ent].slot;
    hit      = entity_map[ent].valid && ({1'b0, s} < live_entries);
    case (kind)
      KIND_ADD: begin
        if (hit) begin
          r.slot = s;
        end else if (live_entries >= SLOT_CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          s                     = live_entries[SLOT_W-1:0];
          entity_map[ent].valid = 1'b1;
          entity_map[ent].slot  = s;
          slot_owner[s]         = ent;
          live_entries          = live_entries + 1'b1;
          r.status              = ST_DONE;
          r.slot                = s;
        end
      end
      KIND_LOOKUP: begin
        if (hit) begin
          r.status = ST_DONE;
          r.slot   = s;
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          shrunk          = live_entries - 1'b1;
          last            = shrunk[SLOT_W-1:0];
          entity_map[ent] = '0;
          // last dense entry fills the hole
          if (s != last) begin
            other                   = slot_owner[last];
            slot_owner[s]           = other;
            entity_map[other].valid = 1'b1;
            entity_map[other].slot  = s;
            r.moved                 = 1'b1;
            r.moved_from_slot       = last;
          end
          live_entries = shrunk;
          r.status     = ST_DONE;
          r.slot       = s;
        end
      end
      default: ;
    endcase
    r.live_count = live_entries;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTITY_SPACE; i++) entity_map[i] = '0;
      live_entries = '0;
      pending_responses.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.status          = status_t'(out_mon.status);
        got.slot            = out_mon.slot;
        got.moved           = out_mon.moved;
        got.moved_from_slot = out_mon.moved_from_slot;
        got.live_count      = out_mon.live_count;
        if (pending_responses.size() == 0) begin
          error_total++;
          if (error_total <= REPORT_LIMIT)
            $display("%0t: response transaction with no request pending", $realtime);
        end else begin
          want = pending_responses.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.moved !== want.moved || got.moved_from_slot !== want.moved_from_slot ||
              got.live_count !== want.live_count) begin
            error_total++;
            if (error_total <= REPORT_LIMIT) begin
              $display("%0t: response mismatch", $realtime);
              $display("  expected status %0d slot %0d moved %0d from %0d count %0d",
                       want.status, want.slot, want.moved, want.moved_from_slot,
                       want.live_count);
              $display("  got      status %0d slot %0d moved %0d from %0d count %0d",
                       got.status, got.slot, got.moved, got.moved_from_slot,
                       got.live_count);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        pending_responses.push_back(resolve_request(in_mon.kind, in_mon.entity_index));
    end
    mismatches  <= error_total;
    outstanding <= pending_responses.size();
  end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives add, lookup and remove requests into the sparse set slot manager:
// a directed opening, then a random phase over a small pool of hot entities
// with a stray index now and then. Both channels idle at random; the receiver
// holds off for long stretches twice. ssm_checker does the prediction and
// comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import ssm_pkg::*;

  // Kind 3 is no operation; the package enum stops at remove.
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

  localparam int RESET_CYCLES    = 10;
  localparam int HOT_COUNT       = 48;
  localparam int RANDOM_ITEMS    = 1333;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 16;
  // Slowest correct run: ~1350 requests, each through the block's states plus
  // the longest send gap and the longest receive stall, then the clearing sweep
  // and two hold-offs. Allow about six times that.
  localparam int TIMEOUT_NS      = 1_500_000;

  logic clk = 1'b0;
  logic rst_n;

  ssm_in_if  in_chan();
  ssm_out_if out_chan();

  int   mismatches;
  int   outstanding;

  // Pacing controls shared by sender and receiver
  logic no_idle       = 1'b0;
  logic sink_hold     = 1'b0;
  int   hold_requests = 0;
  int   stall_left    = 0;

  logic [ENT_W-1:0] hot_entities [HOT_COUNT];

  sparse_set_slot_manager u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  ssm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short idles, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return KIND_ADD;
    if (r < 65) return KIND_LOOKUP;
    if (r < 95) return KIND_REMOVE;
    return KIND_NOP;
  endfunction

  // Hot pool keeps adds, hits and removes colliding; one in ten is anywhere.
  function automatic logic [ENT_W-1:0] pick_entity();
    logic [ENT_W-1:0] e;
    if ($urandom_range(0, 9) == 0) e = ENT_W'($urandom_range(0, ENTITY_SPACE - 1));
    else e = hot_entities[$urandom_range(0, HOT_COUNT - 1)];
    return e;
  endfunction

  // One request transaction. valid stays high across back-to-back requests.
  task automatic offer(logic [KIND_W-1:0] kind, logic [ENT_W-1:0] ent);
    int gap;
    gap = (no_idle || sink_hold) ? 0 : idle_cycles();
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.kind         <= kind;
    in_chan.entity_index <= ent;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Receiver pacing: random stalls, none while no_idle is set, forced low
  // during a hold-off and in reset.
  always @(posedge clk) begin
    if (!rst_n || sink_hold || (!no_idle && stall_left != 0)) begin
      out_chan.ready <= 1'b0;
      if (stall_left != 0) stall_left <= stall_left - 1;
    end else begin
      out_chan.ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 7) == 0) stall_left <= idle_cycles();
    end
  end

  // Long receiver hold-offs, counted here so the sender keeps offering and the
  // block backs up into its input.
  initial begin : receiver_hold_off
    for (int n = 1; n <= 2; n++) begin
      wait (hold_requests >= n);
      @(posedge clk);
      sink_hold <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      sink_hold <= 1'b0;
    end
  end

  initial begin : stimulus
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.kind         <= KIND_ADD;
    in_chan.entity_index <= '0;
    for (int i = 0; i < HOT_COUNT; i++)
      hot_entities[i] = ENT_W'($urandom_range(0, ENTITY_SPACE - 1));
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-set misses, extreme indices, duplicate add, kind 3,
    // remove with and without a move, repeat remove.
    offer(KIND_LOOKUP, 12'h000);
    offer(KIND_REMOVE, 12'hFFF);
    offer(KIND_ADD,    12'h000);
    offer(KIND_ADD,    12'hFFF);
    offer(KIND_ADD,    12'h000);   // already present
    offer(KIND_ADD,    12'hAAA);
    offer(KIND_ADD,    12'h555);
    offer(KIND_LOOKUP, 12'hFFF);
    offer(KIND_NOP,    12'hFFF);
    offer(KIND_NOP,    12'h000);
    offer(KIND_REMOVE, 12'hFFF);   // last entry moves into its slot
    offer(KIND_LOOKUP, 12'h555);
    offer(KIND_REMOVE, 12'hAAA);   // removes the last entry, no move
    offer(KIND_REMOVE, 12'hAAA);   // now absent
    offer(KIND_REMOVE, 12'h000);
    offer(KIND_REMOVE, 12'h555);
    offer(KIND_LOOKUP, 12'h555);

    // Random phase over the hot pool, with two hold-offs and a stretch with
    // no idling on either side.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 600) no_idle <= 1'b1;
      if (i == 800) no_idle <= 1'b0;
      if (i == 150 || i == 1000) hold_requests <= hold_requests + 1;
      offer(pick_kind(), pick_entity());
    end

    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : run_limit
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
